// ----- sv/wpc_pkg.sv -----
// Package for the waypoint heading controller: widths, fixed-point constants,
// the arctangent table and the structs passed between pipeline modules.
// No dependencies.
package wpc_pkg;

    localparam int XW = 52;
    localparam int ZW = 35;
    localparam int BW = 37;
    localparam int HW = 16;
    localparam int DW = 32;
    localparam int GW = 10;
    localparam int SW = 16;
    localparam int TW = 24;
    localparam int CFG_DW = 24;
    localparam int CFG_IW = 2;

    localparam logic [1:0] REG_CRUISE_SPEED = 2'd0;
    localparam logic [1:0] REG_STEER_GAIN   = 2'd1;
    localparam logic [1:0] REG_ARRIVE_THR   = 2'd2;

    localparam logic [SW-1:0] CRUISE_SPEED_RST = 16'd500;
    localparam logic [GW-1:0] STEER_GAIN_RST   = 10'd205;
    localparam logic [TW-1:0] ARRIVE_THR_RST   = 24'd920;

    localparam logic signed [ZW-1:0] PI_Z     = 35'sd3373259426;
    localparam logic signed [BW-1:0] PI_B     = 37'sd3373259426;
    localparam logic signed [BW-1:0] TWO_PI_B = 37'sd6746518852;
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
    localparam logic [17:0] HDG_COARSE = 18'd187403;
    localparam logic [12:0] HDG_FINE   = 13'd5426;
    localparam logic [13:0] HDG_HALF   = 14'd9000;
    localparam logic [29:0] RECIP_18000 = 30'd977343670;

    typedef struct packed {
        logic                  valid;
        logic [XW-2:0]         mag;
        logic signed [ZW-1:0]  angle;
        logic [HW-1:0]         hdg;
    } cordic_out_t;

    typedef struct packed {
        logic                  valid;
        logic [DW-1:0]         dist_val;
        logic [ZW-1:0]         theta;
        logic signed [ZW-1:0]  angle;
    } scale_out_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 35'sh03243F6A8;
            1:  r = 35'sh01DAC6705;
            2:  r = 35'sh00FADBAFC;
            3:  r = 35'sh007F56EA6;
            4:  r = 35'sh003FEAB76;
            5:  r = 35'sh001FFD55B;
            6:  r = 35'sh000FFFAAA;
            7:  r = 35'sh0007FFF55;
            8:  r = 35'sh0003FFFEA;
            9:  r = 35'sh0001FFFFD;
            10: r = 35'sh0000FFFFF;
            11: r = 35'sh00007FFFF;
            12: r = 35'sh00003FFFF;
            13: r = 35'sh00001FFFF;
            14: r = 35'sh00000FFFF;
            15: r = 35'sh000007FFF;
            16: r = 35'sh000003FFF;
            17: r = 35'sh000001FFF;
            18: r = 35'sh000000FFF;
            19: r = 35'sh0000007FF;
            20: r = 35'sh0000003FF;
            21: r = 35'sh0000001FF;
            22: r = 35'sh0000000FF;
            23: r = 35'sh00000007F;
            24: r = 35'sh00000003F;
            25: r = 35'sh00000001F;
            26: r = 35'sh00000000F;
            27: r = 35'sh000000008;
            28: r = 35'sh000000004;
            29: r = 35'sh000000002;
            30: r = 35'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/waypoint_heading_p_controller.sv -----
// Top level of the waypoint heading controller: configuration registers,
// input register and the three pipeline modules. Depends on wpc_pkg.
//
// Usage: drive the position, waypoint and heading ports and raise start for
// one cycle per transaction. busy is always low, so a transaction is taken at
// every clock edge where start is high, one per cycle, back to back.
// Each result appears on the output ports for exactly one cycle, marked by
// done. Results leave in the order taken. Each transaction passes through the
// CORDIC stage chain, the scaling multipliers and the bearing wrap and gain
// stages and the output register; throughput is one per cycle.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect on
// the next edge; write only while no transaction is in flight.
// Reset clears all valid bits and loads cruise speed 500, gain 205 and an
// arrival threshold of 920. The receiver cannot stall the outputs.
module waypoint_heading_p_controller #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [30:0]              pos_lat,
    input  logic signed [31:0]              pos_lon,
    input  logic signed [30:0]              goal_lat,
    input  logic signed [31:0]              goal_lon,
    input  logic [15:0]                     heading,
    input  logic                            cfg_we,
    input  logic [wpc_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [wpc_pkg::CFG_DW-1:0]      cfg_data,
    output logic                            done,
    output logic [15:0]                     forward_speed,
    output logic signed [17:0]              turn_rate,
    output logic signed [15:0]              bearing_error,
    output logic [31:0]                     distance,
    output logic                            moving
);
    import wpc_pkg::*;

    logic [SW-1:0]      cruise_speed_reg;
    logic [GW-1:0]      steer_gain_reg;
    logic [TW-1:0]      arrive_thr_reg;

    logic               in_valid_reg;
    logic signed [31:0] d_lat_reg;
    logic signed [32:0] d_lon_reg;
    logic [HW-1:0]      hdg_reg;

    cordic_out_t        cordic_res;
    scale_out_t         scale_res;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_speed_reg <= CRUISE_SPEED_RST;
            steer_gain_reg   <= STEER_GAIN_RST;
            arrive_thr_reg   <= ARRIVE_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[SW-1:0];
                REG_STEER_GAIN:   steer_gain_reg   <= cfg_data[GW-1:0];
                REG_ARRIVE_THR:   arrive_thr_reg   <= cfg_data[TW-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        d_lat_reg <= {goal_lat[30], goal_lat} - {pos_lat[30], pos_lat};
        d_lon_reg <= {goal_lon[31], goal_lon} - {pos_lon[31], pos_lon};
        hdg_reg   <= heading;
    end

    wpc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .d_lat    (d_lat_reg),
        .d_lon    (d_lon_reg),
        .hdg      (hdg_reg),
        .result   (cordic_res)
    );

    wpc_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .cin    (cordic_res),
        .result (scale_res)
    );

    wpc_steer #(
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_steer (
        .clk              (clk),
        .rst_n            (rst_n),
        .sin              (scale_res),
        .cruise_speed     (cruise_speed_reg),
        .steer_gain       (steer_gain_reg),
        .arrive_threshold (arrive_thr_reg),
        .done             (done),
        .forward_speed    (forward_speed),
        .turn_rate        (turn_rate),
        .bearing_error    (bearing_error),
        .distance         (distance),
        .moving           (moving)
    );

endmodule

// ----- sv/wpc_cordic.sv -----
// Pipelined CORDIC vectoring unit: one pre-rotation stage and one stage per
// iteration. Depends on wpc_pkg.
module wpc_cordic #(
    parameter int STAGES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [31:0]          d_lat,
    input  logic signed [32:0]          d_lon,
    input  logic [wpc_pkg::HW-1:0]      hdg,
    output wpc_pkg::cordic_out_t        result
);
    import wpc_pkg::*;

    logic                 valid_reg [STAGES+1];
    logic                 zero_reg  [STAGES+1];
    logic signed [XW-1:0] x_reg     [STAGES+1];
    logic signed [XW-1:0] y_reg     [STAGES+1];
    logic signed [ZW-1:0] z_reg     [STAGES+1];
    logic [HW-1:0]        hdg_reg   [STAGES+1];

    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    assign x_in = {{(XW-48){d_lat[31]}}, d_lat, 16'b0};
    assign y_in = {{(XW-49){d_lon[32]}}, d_lon, 16'b0};

    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        z_next = '0;
        if (d_lat[31])
        begin
            x_next = -x_in;
            y_next = -y_in;
            z_next = d_lon[32] ? -PI_Z : PI_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
        hdg_reg[0]  <= hdg;
        zero_reg[0] <= (d_lat == '0) && (d_lon == '0);
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] step;

        assign xs   = x_reg[i] >>> i;
        assign ys   = y_reg[i] >>> i;
        assign step = atan_q30(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (!y_reg[i][XW-1])
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + step;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - step;
            end
            hdg_reg[i+1]  <= hdg_reg[i];
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    assign result.valid = valid_reg[STAGES];
    assign result.mag   = x_reg[STAGES][XW-2:0];
    assign result.angle = zero_reg[STAGES] ? '0 : z_reg[STAGES];
    assign result.hdg   = hdg_reg[STAGES];

endmodule

// ----- sv/wpc_scale.sv -----
// Three-stage scaling: distance from the CORDIC magnitude and heading angle
// in Q30 radians from hundredths of a degree. Depends on wpc_pkg.
module wpc_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wpc_pkg::cordic_out_t   cin,
    output wpc_pkg::scale_out_t    result
);
    import wpc_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [50:0]          hi_prod_reg;
    logic [63:0]          lo_prod_reg;
    logic [28:0]          hv_reg;
    logic [33:0]          ha1_reg, ha2_reg;
    logic signed [ZW-1:0] z1_reg, z2_reg, z3_reg;
    logic [51:0]          mid_reg;
    logic [58:0]          p_reg;
    logic [DW-1:0]        dist_reg;
    logic [ZW-1:0]        theta_reg;

    logic [51:0]          mid_rnd;
    logic [35:0]          d_full;

    assign mid_rnd = mid_reg + 52'd32768;
    assign d_full  = mid_rnd[51:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cin.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_prod_reg <= 51'(cin.mag[50:32]) * 51'(INV_GAIN);
        lo_prod_reg <= 64'(cin.mag[31:0]) * 64'(INV_GAIN);
        hv_reg      <= 29'(29'(cin.hdg) * 29'(HDG_FINE) + 29'(HDG_HALF));
        ha1_reg     <= 34'(cin.hdg) * 34'(HDG_COARSE);
        z1_reg      <= cin.angle;

        mid_reg <= 52'(hi_prod_reg) + 52'(lo_prod_reg[63:32]);
        p_reg   <= 59'(hv_reg) * 59'(RECIP_18000);
        ha2_reg <= ha1_reg;
        z2_reg  <= z1_reg;

        dist_reg  <= (d_full[35:32] != '0) ? '1 : d_full[31:0];
        theta_reg <= 35'(ha2_reg) + 35'(p_reg[58:44]);
        z3_reg    <= z2_reg;
    end

    assign result.valid    = v3_reg;
    assign result.dist_val = dist_reg;
    assign result.theta    = theta_reg;
    assign result.angle    = z3_reg;

endmodule

// ----- sv/wpc_steer.sv -----
// Steering stages: bearing error, wrap into (-pi, pi], rounding, gain product
// and the output register. Depends on wpc_pkg.
module wpc_steer #(
    parameter int FRAC_BITS = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wpc_pkg::scale_out_t           sin,
    input  logic [wpc_pkg::SW-1:0]        cruise_speed,
    input  logic [wpc_pkg::GW-1:0]        steer_gain,
    input  logic [wpc_pkg::TW-1:0]        arrive_threshold,
    output logic                          done,
    output logic [15:0]                   forward_speed,
    output logic signed [17:0]            turn_rate,
    output logic signed [15:0]            bearing_error,
    output logic [31:0]                   distance,
    output logic                          moving
);
    import wpc_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [BW-1:0] RND = BW'(1) <<< (SH - 1);

    logic                 v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic                 mv4_reg, mv5_reg, mv6_reg, mv7_reg, mv8_reg;
    logic [DW-1:0]        d4_reg, d5_reg, d6_reg, d7_reg, d8_reg;
    logic signed [BW-1:0] b4_reg, b5_reg, b6_reg;
    logic signed [31:0]   br7_reg, br8_reg;
    logic signed [42:0]   prod_reg;

    logic signed [BW-1:0] b5a, b5b, b6a, b6b, b7_rnd;
    logic signed [42:0]   rate_rnd;
    logic signed [BW-1:0] rate_sh;

    logic                 done_reg;
    logic [15:0]          speed_reg;
    logic signed [17:0]   rate_reg;
    logic signed [15:0]   bear_reg;
    logic [31:0]          dist_reg;
    logic                 moving_reg;

    always_comb
    begin
        b5a = (b4_reg > PI_B) ? b4_reg - TWO_PI_B : b4_reg;
        b5b = (b5a > PI_B) ? b5a - TWO_PI_B : b5a;
        b6a = (b5_reg > PI_B) ? b5_reg - TWO_PI_B : b5_reg;
        b6b = (b6a <= -PI_B) ? b6a + TWO_PI_B : b6a;
    end

    assign b7_rnd   = (b6_reg + RND) >>> SH;
    assign rate_rnd = (prod_reg + 43'sd128) >>> 8;
    assign rate_sh  = BW'(rate_rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= sin.valid;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            done_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b4_reg  <= signed'({2'b00, sin.theta}) - BW'(sin.angle);
        mv4_reg <= sin.dist_val >= {8'b0, arrive_threshold};
        d4_reg  <= sin.dist_val;

        b5_reg  <= b5b;
        mv5_reg <= mv4_reg;
        d5_reg  <= d4_reg;

        b6_reg  <= b6b;
        mv6_reg <= mv5_reg;
        d6_reg  <= d5_reg;

        br7_reg <= b7_rnd[31:0];
        mv7_reg <= mv6_reg;
        d7_reg  <= d6_reg;

        prod_reg <= 43'(signed'({1'b0, steer_gain})) * 43'(br7_reg);
        br8_reg  <= br7_reg;
        mv8_reg  <= mv7_reg;
        d8_reg   <= d7_reg;

        speed_reg  <= mv8_reg ? cruise_speed : '0;
        rate_reg   <= mv8_reg ? rate_sh[17:0] : '0;
        bear_reg   <= br8_reg[15:0];
        dist_reg   <= d8_reg;
        moving_reg <= mv8_reg;
    end

    assign done          = done_reg & v9_reg | done_reg;
    assign forward_speed = speed_reg;
    assign turn_rate     = rate_reg;
    assign bearing_error = bear_reg;
    assign distance      = dist_reg;
    assign moving        = moving_reg;

endmodule
